@@ hw/rtl/drr_pkg.sv @@
// Shared types and constants of the deficit round robin scheduler.
// Used by drr_len_store, drr_mod_unit and deficit_round_robin_scheduler.
// No dependencies.
package drr_pkg;

  localparam int NUM_QUEUES = 4;
  localparam int FIFO_DEPTH = 64;

  // Widths fixed by the item fields.
  localparam int QIDX_W  = 2;
  localparam int LEN_W   = 16;
  localparam int QCNT_W  = 3;
  localparam int STAT_W  = 3;
  localparam int CIDX_W  = 3;
  localparam int QUANT_REGS = 4;

  // Widths that follow from the storage sizes.
  localparam int SLOT_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_QUEUES * FIFO_DEPTH);

  // Remainder unit produces one quotient bit per cycle.
  localparam int DIV_STEPS = LEN_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Stream widths: tdata rounded up to whole bytes.
  localparam int S_DATA_W = ((QIDX_W + LEN_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((QIDX_W + 2 * LEN_W + 7) / 8) * 8;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_QUANTUM0      = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_QUEUES_IN_USE = 3'd4;

  localparam logic [LEN_W-1:0]  QUANTUM_RESET = 16'd1500;

  typedef enum logic [STAT_W-1:0] {
    ST_ENQUEUED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_SCHEDULED = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BADQ      = 3'd4
  } status_t;

  typedef enum logic {
    KIND_ENQUEUE = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] rem;
  } mod_rsp_t;

endpackage

@@ hw/rtl/drr_len_store.sv @@
// Packet length store shared by all queues, one region per queue.
// Depends on drr_pkg for widths.
module drr_len_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [drr_pkg::ADDR_W-1:0] waddr,
  input  logic [drr_pkg::LEN_W-1:0]  wdata,
  input  logic                       re,
  input  logic [drr_pkg::ADDR_W-1:0] raddr,
  output logic [drr_pkg::LEN_W-1:0]  rdata
);

  logic [drr_pkg::LEN_W-1:0] mem [drr_pkg::NUM_QUEUES * drr_pkg::FIFO_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/drr_mod_unit.sv @@
// Restoring remainder unit: one quotient bit per cycle.
// Depends on drr_pkg for the request and response types.
module drr_mod_unit (
  input  logic              clk,
  input  logic              rst,
  input  drr_pkg::mod_req_t req,
  output drr_pkg::mod_rsp_t rsp
);

  logic                       busy;
  logic                       done;
  logic [drr_pkg::DCNT_W-1:0] cnt;
  logic [drr_pkg::LEN_W-1:0]  rem;
  logic [drr_pkg::LEN_W-1:0]  dvd;
  logic [drr_pkg::LEN_W-1:0]  dsr;
  logic [drr_pkg::LEN_W:0]    trial;
  logic [drr_pkg::LEN_W:0]    diff;

  assign trial = {rem, dvd[drr_pkg::LEN_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= req.dividend;
        dsr  <= req.divisor;
      end else if (busy) begin
        // The partial remainder stays below the divisor, so trial fits.
        if (!diff[drr_pkg::LEN_W]) begin
          rem <= diff[drr_pkg::LEN_W-1:0];
        end else begin
          rem <= trial[drr_pkg::LEN_W-1:0];
        end
        dvd <= {dvd[drr_pkg::LEN_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == drr_pkg::DCNT_W'(drr_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

  a_nonzero_divisor: assert property (@(posedge clk) disable iff (rst)
    req.start |-> req.divisor != '0)
    else $error("remainder unit started with a zero divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start)
    else $error("remainder unit restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("remainder done without a running division");

endmodule

@@ hw/rtl/deficit_round_robin_scheduler.sv @@
// Deficit round robin scheduler over up to four packet-length FIFOs.
// An enqueue beat goes through S_ENQ and S_REPORT to its result beat. A request
// beat goes through the scan, which looks at one queue per cycle (up to four), a
// registered read of the head length from the length store and, when the deficit
// does not cover the head, the shared remainder unit, which settles the leftover
// credit one bit per cycle. One beat is worked on at a time; a finished result
// waits in the output register without holding up acceptance of the next beat.
// The length store needs no clearing after reset. Depends on drr_pkg, drr_len_store
// and drr_mod_unit.
module deficit_round_robin_scheduler (
  input  logic                         clk,
  input  logic                         rst,
  // Input beats.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [drr_pkg::S_DATA_W-1:0] s_tdata,  // queue_index, packet_length, zero fill
  input  logic                         s_tuser,  // kind
  // Result beats.
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [drr_pkg::M_DATA_W-1:0] m_tdata,  // served_queue, served_length,
                                                 // deficit_after, zero fill
  output logic [drr_pkg::STAT_W-1:0]   m_tuser,  // status
  // Configuration writes.
  input  logic                         cfg_we,
  input  logic [drr_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [drr_pkg::LEN_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_SCAN,
    S_READ,
    S_DIV,
    S_FINISH,
    S_REPORT
  } state_t;

  state_t state;

  // Configuration.
  logic [drr_pkg::LEN_W-1:0]  quantum [drr_pkg::QUANT_REGS];
  logic [drr_pkg::QCNT_W-1:0] queues_in_use;

  // Per-queue state.
  logic [drr_pkg::FILL_W-1:0] fill_count [drr_pkg::NUM_QUEUES];
  logic [drr_pkg::SLOT_W-1:0] read_slot  [drr_pkg::NUM_QUEUES];
  logic [drr_pkg::SLOT_W-1:0] write_slot [drr_pkg::NUM_QUEUES];
  logic [drr_pkg::LEN_W-1:0]  deficit    [drr_pkg::NUM_QUEUES];
  logic [drr_pkg::QIDX_W-1:0] round_pointer;

  // Working registers of the current beat.
  logic [drr_pkg::QIDX_W-1:0] cur_q;
  logic [drr_pkg::QIDX_W-1:0] scan_cnt;
  logic [drr_pkg::LEN_W-1:0]  in_len;
  logic [drr_pkg::LEN_W-1:0]  head_len;
  logic [drr_pkg::LEN_W-1:0]  res_def;
  logic [drr_pkg::LEN_W-1:0]  res_len;
  logic [drr_pkg::QIDX_W-1:0] res_q;
  drr_pkg::status_t           res_status;

  logic [drr_pkg::QCNT_W-1:0] n_active;
  logic [drr_pkg::QCNT_W-1:0] next_q_wide;
  logic [drr_pkg::QIDX_W-1:0] next_q;
  logic [drr_pkg::QIDX_W-1:0] start_q;
  logic [drr_pkg::LEN_W-1:0]  cur_quant;
  logic [drr_pkg::LEN_W-1:0]  cur_def;
  logic [drr_pkg::FILL_W-1:0] cur_fill;
  logic [drr_pkg::SLOT_W-1:0] cur_wslot;
  logic [drr_pkg::SLOT_W-1:0] cur_rslot;
  logic                       s_accept;
  logic                       out_free;

  logic                       mem_we;
  logic                       mem_re;
  logic [drr_pkg::ADDR_W-1:0] mem_waddr;
  logic [drr_pkg::ADDR_W-1:0] mem_raddr;
  logic [drr_pkg::LEN_W-1:0]  mem_rdata;

  drr_pkg::mod_req_t mod_req;
  drr_pkg::mod_rsp_t mod_rsp;

  always_comb begin
    priority if (queues_in_use == '0) begin
      n_active = drr_pkg::QCNT_W'(1);
    end else if (queues_in_use > drr_pkg::QCNT_W'(drr_pkg::NUM_QUEUES)) begin
      n_active = drr_pkg::QCNT_W'(drr_pkg::NUM_QUEUES);
    end else begin
      n_active = queues_in_use;
    end
  end

  assign start_q     = ({1'b0, round_pointer} < n_active) ? round_pointer : '0;
  assign next_q_wide = {1'b0, cur_q} + 1'b1;
  assign next_q      = (next_q_wide == n_active) ? '0 : next_q_wide[drr_pkg::QIDX_W-1:0];

  assign cur_quant = (quantum[cur_q] == '0) ? drr_pkg::LEN_W'(1) : quantum[cur_q];
  assign cur_def   = deficit[cur_q];
  assign cur_fill  = fill_count[cur_q];
  assign cur_wslot = write_slot[cur_q];
  assign cur_rslot = read_slot[cur_q];

  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Each queue owns FIFO_DEPTH consecutive entries of the length store.
  assign mem_waddr = drr_pkg::ADDR_W'(cur_q) * drr_pkg::ADDR_W'(drr_pkg::FIFO_DEPTH)
                   + drr_pkg::ADDR_W'(cur_wslot);
  assign mem_raddr = drr_pkg::ADDR_W'(cur_q) * drr_pkg::ADDR_W'(drr_pkg::FIFO_DEPTH)
                   + drr_pkg::ADDR_W'(cur_rslot);
  assign mem_we = (state == S_ENQ) && ({1'b0, cur_q} < n_active)
               && (cur_fill != drr_pkg::FILL_W'(drr_pkg::FIFO_DEPTH));
  assign mem_re = (state == S_SCAN) && (cur_fill != '0);

  // Top-up is needed only when the deficit falls short of the head length.
  assign mod_req.start    = (state == S_READ) && (cur_def < mem_rdata);
  assign mod_req.dividend = mem_rdata - cur_def;
  assign mod_req.divisor  = cur_quant;

  drr_len_store u_len_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_len),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  drr_mod_unit u_mod_unit (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < drr_pkg::QUANT_REGS; i++) begin
        quantum[i] <= drr_pkg::QUANTUM_RESET;
      end
      queues_in_use <= drr_pkg::QCNT_W'(drr_pkg::NUM_QUEUES);
    end else if (cfg_we) begin
      priority if (cfg_index < drr_pkg::CFG_QUEUES_IN_USE) begin
        quantum[cfg_index[drr_pkg::QIDX_W-1:0] - drr_pkg::CFG_QUANTUM0[drr_pkg::QIDX_W-1:0]]
          <= cfg_data;
      end else if (cfg_index == drr_pkg::CFG_QUEUES_IN_USE) begin
        queues_in_use <= cfg_data[drr_pkg::QCNT_W-1:0];
      end else begin
        queues_in_use <= queues_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      round_pointer <= '0;
      cur_q         <= '0;
      for (int i = 0; i < drr_pkg::NUM_QUEUES; i++) begin
        fill_count[i] <= '0;
        read_slot[i]  <= '0;
        write_slot[i] <= '0;
        deficit[i]    <= '0;
      end
    end else begin
      // The report step reloads the output register itself.
      if (m_tvalid && m_tready && state != S_REPORT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            in_len <= s_tdata[drr_pkg::QIDX_W +: drr_pkg::LEN_W];
            if (s_tuser == drr_pkg::KIND_ENQUEUE) begin
              cur_q <= s_tdata[drr_pkg::QIDX_W-1:0];
              state <= S_ENQ;
            end else begin
              cur_q    <= start_q;
              scan_cnt <= '0;
              state    <= S_SCAN;
            end
          end
        end
        S_ENQ: begin
          res_q   <= cur_q;
          res_len <= '0;
          res_def <= '0;
          priority if ({1'b0, cur_q} >= n_active) begin
            res_status <= drr_pkg::ST_BADQ;
          end else if (cur_fill == drr_pkg::FILL_W'(drr_pkg::FIFO_DEPTH)) begin
            res_status <= drr_pkg::ST_FULL;
          end else begin
            res_status        <= drr_pkg::ST_ENQUEUED;
            fill_count[cur_q] <= cur_fill + 1'b1;
            write_slot[cur_q] <= (cur_wslot == drr_pkg::SLOT_W'(drr_pkg::FIFO_DEPTH - 1))
                               ? '0 : cur_wslot + 1'b1;
          end
          state <= S_REPORT;
        end
        S_SCAN: begin
          priority if (cur_fill != '0) begin
            state <= S_READ;
          end else if ({1'b0, scan_cnt} == n_active - 1'b1) begin
            res_status <= drr_pkg::ST_EMPTY;
            res_q      <= '0;
            res_len    <= '0;
            res_def    <= '0;
            state      <= S_REPORT;
          end else begin
            cur_q    <= next_q;
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_READ: begin
          head_len <= mem_rdata;
          if (cur_def < mem_rdata) begin
            state <= S_DIV;
          end else begin
            res_def <= cur_def - mem_rdata;
            state   <= S_FINISH;
          end
        end
        S_DIV: begin
          // Credit left after k top-ups is (quantum - remainder) mod quantum.
          if (mod_rsp.done) begin
            res_def <= (mod_rsp.rem == '0) ? '0 : cur_quant - mod_rsp.rem;
            state   <= S_FINISH;
          end
        end
        S_FINISH: begin
          deficit[cur_q]    <= res_def;
          fill_count[cur_q] <= cur_fill - 1'b1;
          read_slot[cur_q]  <= (cur_rslot == drr_pkg::SLOT_W'(drr_pkg::FIFO_DEPTH - 1))
                             ? '0 : cur_rslot + 1'b1;
          round_pointer     <= next_q;
          res_status        <= drr_pkg::ST_SCHEDULED;
          res_q             <= cur_q;
          res_len           <= head_len;
          state             <= S_REPORT;
        end
        S_REPORT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {(drr_pkg::M_DATA_W - drr_pkg::QIDX_W - 2 * drr_pkg::LEN_W)'(0),
                         res_def, res_len, res_q};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_mem_collision: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("length store written and read in the same cycle");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    cur_fill <= drr_pkg::FILL_W'(drr_pkg::FIFO_DEPTH))
    else $error("queue fill count beyond FIFO depth");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> state == S_DIV)
    else $error("remainder result arrived outside the top-up step");

  a_report_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPORT && out_free) |=> m_tvalid && state == S_IDLE)
    else $error("result beat not presented after report");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH |-> cur_fill != '0)
    else $error("pop from an empty queue");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for deficit_round_robin_scheduler: a directed table and then
// random phases; known rows are checked against the table, the rest against a predictor
// of the scheduler kept in the testbench. Depends on drr_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

module tb_top;
  import drr_pkg::*;

  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 240;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;

  localparam logic [CIDX_W-1:0] CFG_QUANTUM1 = CFG_QUANTUM0 + 3'd1;
  localparam logic [CIDX_W-1:0] CFG_QUANTUM2 = CFG_QUANTUM0 + 3'd2;
  localparam logic [CIDX_W-1:0] CFG_QUANTUM3 = CFG_QUANTUM0 + 3'd3;

  typedef struct packed {
    status_t           status;
    logic [QIDX_W-1:0] queue;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  deficit;
  } drr_result_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_PREDICT,
    ROW_KNOWN
  } row_op_t;

  typedef struct packed {
    row_op_t           op;
    logic [CIDX_W-1:0] cfg_idx;
    kind_t             kind;
    logic [QIDX_W-1:0] qi;
    logic [LEN_W-1:0]  len;     // packet length, or the register value of a write
    drr_result_t       want;
  } dir_row_t;

  localparam drr_result_t UNTYPED = '0;
  localparam int N_DIRECTED = 28;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // queue_index, packet_length, zero fill
  logic                s_tuser;   // kind
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // served_queue, served_length, deficit_after, zero fill
  logic [STAT_W-1:0]   m_tuser;   // status
  logic                cfg_we;
  logic [CIDX_W-1:0]   cfg_index;
  logic [LEN_W-1:0]    cfg_data;

  // Shadow of the scheduler state.
  logic [LEN_W-1:0]  len_fifo [NUM_QUEUES][FIFO_DEPTH];
  int unsigned       fill [NUM_QUEUES];
  int unsigned       rd_slot [NUM_QUEUES];
  int unsigned       wr_slot [NUM_QUEUES];
  int unsigned       credit [NUM_QUEUES];
  int unsigned       rr_ptr = 0;
  logic [LEN_W-1:0]  quantum_shadow [QUANT_REGS] = '{default: QUANTUM_RESET};
  logic [QCNT_W-1:0] in_use_shadow = 3'd4;

  drr_result_t awaited_results [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          status_seen [5];
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          hold_cycles_req = 0;
  int          hold_left = 0;
  int unsigned cycles = 0;

  // Known rows are those whose result follows from reset values or a plain rule.
  dir_row_t directed [N_DIRECTED] = '{
    '{ROW_KNOWN,   CFG_QUANTUM0, KIND_REQUEST, 2'd0, 16'd0,     '{ST_EMPTY, 2'd0, 16'd0, 16'd0}},
    '{ROW_KNOWN,   CFG_QUANTUM0, KIND_ENQUEUE, 2'd0, 16'd0,     '{ST_ENQUEUED, 2'd0, 16'd0, 16'd0}},
    '{ROW_KNOWN,   CFG_QUANTUM0, KIND_ENQUEUE, 2'd2, 16'hFFFF,  '{ST_ENQUEUED, 2'd2, 16'd0, 16'd0}},
    '{ROW_KNOWN,   CFG_QUANTUM0, KIND_ENQUEUE, 2'd3, 16'd1,     '{ST_ENQUEUED, 2'd3, 16'd0, 16'd0}},
    // A zero-length head goes out with no top-up.
    '{ROW_KNOWN,   CFG_QUANTUM0, KIND_REQUEST, 2'd0, 16'd0,     '{ST_SCHEDULED, 2'd0, 16'd0, 16'd0}},
    '{ROW_PREDICT, CFG_QUANTUM0, KIND_REQUEST, 2'd0, 16'd0,     UNTYPED},
    '{ROW_WRITE,   CFG_QUANTUM1, KIND_ENQUEUE, 2'd0, 16'd0,     UNTYPED},
    '{ROW_WRITE,   CFG_QUANTUM0, KIND_ENQUEUE, 2'd0, 16'hFFFF,  UNTYPED},
    '{ROW_WRITE,   CFG_QUEUES_IN_USE, KIND_ENQUEUE, 2'd0, 16'd2, UNTYPED},
    '{ROW_KNOWN,   CFG_QUANTUM0, KIND_ENQUEUE, 2'd3, 16'd5,     '{ST_BADQ, 2'd3, 16'd0, 16'd0}},
    '{ROW_KNOWN,   CFG_QUANTUM0, KIND_ENQUEUE, 2'd1, 16'hFFFF,  '{ST_ENQUEUED, 2'd1, 16'd0, 16'd0}},
    '{ROW_KNOWN,   CFG_QUANTUM0, KIND_ENQUEUE, 2'd0, 16'd300,   '{ST_ENQUEUED, 2'd0, 16'd0, 16'd0}},
    // The round pointer still names queue 3, beyond the two queues now in use.
    '{ROW_PREDICT, CFG_QUANTUM0, KIND_REQUEST, 2'd3, 16'hFFFF,  UNTYPED},
    '{ROW_PREDICT, CFG_QUANTUM0, KIND_REQUEST, 2'd0, 16'd0,     UNTYPED},
    // Queue 3 still holds a packet, but it is out of the round.
    '{ROW_KNOWN,   CFG_QUANTUM0, KIND_REQUEST, 2'd0, 16'd0,     '{ST_EMPTY, 2'd0, 16'd0, 16'd0}},
    '{ROW_WRITE,   CFG_QUEUES_IN_USE, KIND_ENQUEUE, 2'd0, 16'd7, UNTYPED},
    '{ROW_KNOWN,   CFG_QUANTUM0, KIND_ENQUEUE, 2'd3, 16'hFFFF,  '{ST_ENQUEUED, 2'd3, 16'd0, 16'd0}},
    '{ROW_PREDICT, CFG_QUANTUM0, KIND_REQUEST, 2'd0, 16'd0,     UNTYPED},
    '{ROW_PREDICT, CFG_QUANTUM0, KIND_REQUEST, 2'd0, 16'd0,     UNTYPED},
    '{ROW_WRITE,   CFG_QUEUES_IN_USE, KIND_ENQUEUE, 2'd0, 16'd0, UNTYPED},
    '{ROW_KNOWN,   CFG_QUANTUM0, KIND_ENQUEUE, 2'd1, 16'd2,     '{ST_BADQ, 2'd1, 16'd0, 16'd0}},
    '{ROW_KNOWN,   CFG_QUANTUM0, KIND_ENQUEUE, 2'd0, 16'hFFFF,  '{ST_ENQUEUED, 2'd0, 16'd0, 16'd0}},
    '{ROW_PREDICT, CFG_QUANTUM0, KIND_REQUEST, 2'd0, 16'd0,     UNTYPED},
    '{ROW_WRITE,   CFG_QUANTUM2, KIND_ENQUEUE, 2'd0, 16'd1,     UNTYPED},
    '{ROW_WRITE,   CFG_QUANTUM3, KIND_ENQUEUE, 2'd0, 16'hFFFF,  UNTYPED},
    '{ROW_WRITE,   CFG_QUEUES_IN_USE, KIND_ENQUEUE, 2'd0, 16'd4, UNTYPED},
    '{ROW_PREDICT, CFG_QUANTUM0, KIND_ENQUEUE, 2'd2, 16'd40,    UNTYPED},
    '{ROW_PREDICT, CFG_QUANTUM0, KIND_REQUEST, 2'd0, 16'd0,     UNTYPED}
  };

  deficit_round_robin_scheduler DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned queues_active();
    if (in_use_shadow == 0) return 1;
    if (in_use_shadow > NUM_QUEUES) return NUM_QUEUES;
    return in_use_shadow;
  endfunction

  // Works out the result of one beat and moves the shadow state on.
  function automatic drr_result_t drr_decide(input kind_t kind, input logic [QIDX_W-1:0] qi,
                                             input logic [LEN_W-1:0] len);
    drr_result_t res;
    int unsigned n, start, q, head, quant, d;
    res = '0;
    res.status = ST_EMPTY;
    n = queues_active();
    if (kind == KIND_ENQUEUE) begin
      res.queue = qi;
      if (qi >= n) begin
        res.status = ST_BADQ;
      end else if (fill[qi] >= FIFO_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        len_fifo[qi][wr_slot[qi]] = len;
        wr_slot[qi] = (wr_slot[qi] + 1) % FIFO_DEPTH;
        fill[qi]++;
        res.status = ST_ENQUEUED;
      end
      return res;
    end
    start = (rr_ptr < n) ? rr_ptr : 0;
    for (int i = 0; i < n; i++) begin
      q = (start + i) % n;
      if (fill[q] != 0) begin
        head = len_fifo[q][rd_slot[q]];
        quant = (quantum_shadow[q] == 0) ? 1 : quantum_shadow[q];
        d = credit[q];
        // Top up in whole quanta until the head fits.
        if (d < head) d += ((head - d + quant - 1) / quant) * quant;
        credit[q] = (d - head) & 32'hFFFF;
        rd_slot[q] = (rd_slot[q] + 1) % FIFO_DEPTH;
        fill[q]--;
        rr_ptr = (q + 1) % n;
        res.status = ST_SCHEDULED;
        res.queue = q[QIDX_W-1:0];
        res.length = head[LEN_W-1:0];
        res.deficit = credit[q][LEN_W-1:0];
        return res;
      end
    end
    return res;
  endfunction

  function automatic logic [LEN_W-1:0] rand_length();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return LEN_W'($urandom);
      default: return LEN_W'($urandom_range(1, 1600));
    endcase
  endfunction

  // Mostly a queue in the round, now and then any queue at all.
  function automatic logic [QIDX_W-1:0] pick_queue();
    if ($urandom_range(9) == 0) return QIDX_W'($urandom_range(NUM_QUEUES - 1));
    return QIDX_W'($urandom_range(queues_active() - 1));
  endfunction

  task automatic send_item(input kind_t kind, input logic [QIDX_W-1:0] qi,
                           input logic [LEN_W-1:0] len, input bit known,
                           input drr_result_t typed);
    drr_result_t res;
    cfg_we <= 1'b0;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'({len, qi});
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = drr_decide(kind, qi, len);
    awaited_results.push_back(known ? typed : res);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Leaves the write enable high; the next beat sent lowers it.
  task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == CFG_QUEUES_IN_USE) in_use_shadow = val[QCNT_W-1:0];
    else quantum_shadow[idx - CFG_QUANTUM0] = val;
  endtask

  function automatic void check_result();
    drr_result_t want;
    if (awaited_results.size() == 0) begin
      $error("result beat with nothing awaited: status %0d", m_tuser);
      mismatches++;
      return;
    end
    want = awaited_results.pop_front();
    if (m_tuser < 5) status_seen[m_tuser]++;
    if (m_tuser !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, m_tuser);
      mismatches++;
    end
    if (m_tdata[QIDX_W-1:0] !== want.queue) begin
      $error("served_queue: expected %0d, got %0d", want.queue, m_tdata[QIDX_W-1:0]);
      mismatches++;
    end
    if (m_tdata[QIDX_W +: LEN_W] !== want.length) begin
      $error("served_length: expected %0d, got %0d", want.length, m_tdata[QIDX_W +: LEN_W]);
      mismatches++;
    end
    if (m_tdata[QIDX_W + LEN_W +: LEN_W] !== want.deficit) begin
      $error("deficit_after: expected %0d, got %0d", want.deficit,
             m_tdata[QIDX_W + LEN_W +: LEN_W]);
      mismatches++;
    end
  endfunction

  // Result side: checks each beat taken, then decides whether to stall the next cycle.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_result();
      if (hold_cycles_req != 0) begin
        hold_left = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("** deficit_round_robin_scheduler: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [QIDX_W-1:0] qi;
    logic [LEN_W-1:0]  qv;
    int                sent;
    bit                paused;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].op == ROW_WRITE) begin
        wait_drained();
        write_register(directed[i].cfg_idx, directed[i].len);
      end else begin
        send_item(directed[i].kind, directed[i].qi, directed[i].len,
                  directed[i].op == ROW_KNOWN, directed[i].want);
      end
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_drained();
      src_idle_pct   = (phase % 4 == 1) ? 55 : (phase % 4 == 3) ? 29 : 0;
      sink_stall_pct = (phase % 4 == 2) ? 55 : (phase % 4 == 3) ? 29 : 0;
      // Phase 1 runs every quantum at its top, phase 2 at its bottom.
      for (int r = 0; r < QUANT_REGS; r++) begin
        case (phase)
          1: qv = '1;
          2: qv = 16'd1;
          default:
            case ($urandom_range(7))
              0: qv = '0;
              1: qv = 16'd1;
              2: qv = '1;
              3, 4: qv = LEN_W'($urandom_range(64, 2000));
              default: qv = LEN_W'($urandom);
            endcase
        endcase
        write_register(CFG_QUANTUM0 + CIDX_W'(r), qv);
      end
      case ($urandom_range(5))
        0, 1: qv = 16'd4;
        2: qv = LEN_W'($urandom_range(1, 3));
        3: qv = 16'd0;
        4: qv = LEN_W'($urandom_range(5, 7));
        default: qv = LEN_W'($urandom_range(7));
      endcase
      write_register(CFG_QUEUES_IN_USE, (phase < 3) ? 16'd4 : qv);
      // The sink goes quiet for a while so that the input side backs up.
      if (phase == 0) hold_cycles_req = HOLD_CYCLES;

      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        if (!paused && sent >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        case ($urandom_range(11))
          0: begin
            // Enough enqueues to one queue to fill its FIFO, and past FIFO_DEPTH to run it over.
            qi = pick_queue();
            repeat ($urandom_range(64, 70)) begin
              send_item(KIND_ENQUEUE, qi, rand_length(), 1'b0, UNTYPED);
              sent++;
            end
          end
          1, 2, 3: begin
            repeat ($urandom_range(5, 40)) begin
              send_item(KIND_REQUEST, QIDX_W'($urandom), LEN_W'($urandom), 1'b0, UNTYPED);
              sent++;
            end
          end
          4: begin
            repeat ($urandom_range(3, 12)) begin
              send_item(kind_t'($urandom_range(1)), QIDX_W'($urandom), LEN_W'($urandom),
                        1'b0, UNTYPED);
              sent++;
            end
          end
          default: begin
            repeat ($urandom_range(4, 20)) begin
              if ($urandom_range(99) < 55)
                send_item(KIND_ENQUEUE, pick_queue(), rand_length(), 1'b0, UNTYPED);
              else
                send_item(KIND_REQUEST, QIDX_W'($urandom), LEN_W'($urandom), 1'b0, UNTYPED);
              sent++;
            end
          end
        endcase
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d beats over a directed table and %0d random phases of quanta and queue counts.",
             items_sent, N_PHASES);
    $display("Results: %0d enqueued, %0d dropped full, %0d scheduled, %0d all empty, %0d bad queue.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("** deficit_round_robin_scheduler: PASSED **");
    end else begin
      $display("** deficit_round_robin_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
